[src/imufd_pkg.sv]
package imufd_pkg;

  // Squared magnitudes and the 32-bit limit registers
  localparam int unsigned SqW    = 32;
  // Window and tick registers
  localparam int unsigned WinW   = 4;
  // Stage counters hold one more bit than the windows
  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FREE_FALL_LIMIT_SQ = 3'd0,
    REG_IMPACT_LIMIT_SQ    = 3'd1,
    REG_ROTATION_LOW_SQ    = 3'd2,
    REG_ROTATION_HIGH_SQ   = 3'd3,
    REG_FREE_FALL_WINDOW   = 3'd4,
    REG_IMPACT_CHECK_TICK  = 3'd5,
    REG_IMPACT_WINDOW      = 3'd6
  } cfg_reg_e;

  localparam logic [SqW-1:0]  FreeFallLimitRst = 32'd0;
  localparam logic [SqW-1:0]  ImpactLimitRst   = 32'd3221225472;
  localparam logic [SqW-1:0]  RotationLowRst   = 32'd2304;
  localparam logic [SqW-1:0]  RotationHighRst  = 32'd40960000;
  localparam logic [WinW-1:0] FreeFallWinRst   = 4'd10;
  localparam logic [WinW-1:0] ImpactTickRst    = 4'd5;
  localparam logic [WinW-1:0] ImpactWinRst     = 4'd12;

endpackage

[src/imufd_mag_sq.sv]
module imufd_mag_sq import imufd_pkg::*; #(
  parameter int unsigned W = 16
) (
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  logic signed [W-1:0] z_i,
  output logic [SqW-1:0]      sq_o
);

  localparam int unsigned ProdW = 2 * W;
  localparam int unsigned SumW  = ProdW + 2;

  logic [W-1:0]     mag_x, mag_y, mag_z;
  logic [ProdW-1:0] prod_x, prod_y, prod_z;
  logic [SumW-1:0]  sum;

  // Two's complement magnitude; the most negative value maps to 2^(W-1)
  assign mag_x = x_i[W-1] ? W'(~x_i + 1'b1) : W'(x_i);
  assign mag_y = y_i[W-1] ? W'(~y_i + 1'b1) : W'(y_i);
  assign mag_z = z_i[W-1] ? W'(~z_i + 1'b1) : W'(z_i);

  assign prod_x = ProdW'(mag_x) * ProdW'(mag_x);
  assign prod_y = ProdW'(mag_y) * ProdW'(mag_y);
  assign prod_z = ProdW'(mag_z) * ProdW'(mag_z);

  assign sum = SumW'(prod_x) + SumW'(prod_y) + SumW'(prod_z);

  // Saturate to 32 bits for wide samples
  always_comb begin
    if (sum > SumW'(33'h0_FFFF_FFFF)) begin
      sq_o = '1;
    end else begin
      sq_o = SqW'(sum);
    end
  end

endmodule

[src/imu_fall_detector.sv]
// Three-stage IMU fall detector on squared acceleration and gyro magnitudes.
// Each item passes the input register, the squared-magnitude register (three
// parallel squarers per magnitude) and the state/result register in turn.
// Throughput: one item per cycle while out_stall_i does not hold the pipeline.
// Reset (rst_ni low, asynchronous): pipeline empties, all detector state
// clears and the configuration registers return to their default values.
module imu_fall_detector import imufd_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] accel_z_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_x_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_y_i,
  input  logic signed [SAMPLE_WIDTH-1:0] gyro_z_i,
  input  logic                          reset_pressed_i,
  // Result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          fall_detected_o,
  output logic                          free_fall_armed_o,
  output logic                          impact_armed_o,
  output logic                          rotation_armed_o,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CfgIdxW-1:0]            cfg_index_i,
  input  logic [SqW-1:0]                cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must land only while the block is idle;
  // the user keeps to it, the block does not enforce it. The port is always ready.
  // ---------------------------------------------------------------------------
  logic [SqW-1:0]  free_fall_limit_q, impact_limit_q, rot_low_q, rot_high_q;
  logic [WinW-1:0] free_fall_win_q, impact_tick_q, impact_win_q;
  logic            cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_fall_limit_q <= FreeFallLimitRst;
      impact_limit_q    <= ImpactLimitRst;
      rot_low_q         <= RotationLowRst;
      rot_high_q        <= RotationHighRst;
      free_fall_win_q   <= FreeFallWinRst;
      impact_tick_q     <= ImpactTickRst;
      impact_win_q      <= ImpactWinRst;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FREE_FALL_LIMIT_SQ: free_fall_limit_q <= cfg_data_i;
        REG_IMPACT_LIMIT_SQ:    impact_limit_q    <= cfg_data_i;
        REG_ROTATION_LOW_SQ:    rot_low_q         <= cfg_data_i;
        REG_ROTATION_HIGH_SQ:   rot_high_q        <= cfg_data_i;
        REG_FREE_FALL_WINDOW:   free_fall_win_q   <= cfg_data_i[WinW-1:0];
        REG_IMPACT_CHECK_TICK:  impact_tick_q     <= cfg_data_i[WinW-1:0];
        REG_IMPACT_WINDOW:      impact_win_q      <= cfg_data_i[WinW-1:0];
        default: ;  // index past the register list: write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow. Each stage loads when it is empty or its content moves
  // on, so items enter while a result waits at the output until s1 and s2 fill.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic out_free, s2_free, s1_free;
  logic s1_load, s2_load, out_load;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_free    = !s1_valid_q || s2_free;
  assign s1_load    = in_valid_i && s1_free;
  assign s2_load    = s1_valid_q && s2_free;
  assign out_load   = s2_valid_q && out_free;
  assign in_stall_o = !s1_free;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free)  s1_valid_q  <= in_valid_i;
      if (s2_free)  s2_valid_q  <= s1_valid_q;
      if (out_free) out_valid_q <= s2_valid_q;
    end
  end

  // Stage 1: raw sample register
  logic signed [SAMPLE_WIDTH-1:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
  logic                           s1_rst_q;

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      ax_q     <= accel_x_i;
      ay_q     <= accel_y_i;
      az_q     <= accel_z_i;
      gx_q     <= gyro_x_i;
      gy_q     <= gyro_y_i;
      gz_q     <= gyro_z_i;
      s1_rst_q <= reset_pressed_i;
    end
  end

  // Stage 2: squared magnitudes, saturated to 32 bits
  logic [SqW-1:0] acc_sq, rot_sq;
  logic [SqW-1:0] acc_sq_q, rot_sq_q;
  logic           s2_rst_q;

  imufd_mag_sq #(.W(SAMPLE_WIDTH)) u_acc_sq (
    .x_i  (ax_q),
    .y_i  (ay_q),
    .z_i  (az_q),
    .sq_o (acc_sq)
  );

  imufd_mag_sq #(.W(SAMPLE_WIDTH)) u_rot_sq (
    .x_i  (gx_q),
    .y_i  (gy_q),
    .z_i  (gz_q),
    .sq_o (rot_sq)
  );

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      acc_sq_q <= acc_sq;
      rot_sq_q <= rot_sq;
      s2_rst_q <= s1_rst_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: detector state. The state registers double as the result
  // register, since every result is the state after its sample.
  // ---------------------------------------------------------------------------
  logic            ff_q, imp_q, rot_q, latch_q;
  logic            ff_d, imp_d, rot_d, latch_d;
  logic [CntW-1:0] ff_cnt_q, imp_cnt_q, ff_cnt_d, imp_cnt_d;
  logic [CntW-1:0] ff_cnt_inc, imp_cnt_inc;
  logic [SqW-1:0]  saved_rot_q, saved_rot_d;

  assign ff_cnt_inc  = ff_cnt_q + 1'b1;
  assign imp_cnt_inc = imp_cnt_q + 1'b1;

  always_comb begin
    ff_d        = ff_q;
    imp_d       = imp_q;
    rot_d       = rot_q;
    latch_d     = latch_q;
    ff_cnt_d    = ff_cnt_q;
    imp_cnt_d   = imp_cnt_q;
    saved_rot_d = saved_rot_q;

    if (latch_q) begin
      // Latched fall: only the button does anything, and it clears all
      if (s2_rst_q) begin
        ff_d        = 1'b0;
        imp_d       = 1'b0;
        rot_d       = 1'b0;
        latch_d     = 1'b0;
        ff_cnt_d    = '0;
        imp_cnt_d   = '0;
        saved_rot_d = '0;
      end
    end else begin
      // Free fall
      if (acc_sq_q <= free_fall_limit_q) ff_d = 1'b1;

      if (ff_d) begin
        if (ff_cnt_q == '0) saved_rot_d = rot_sq_q;
        if (ff_cnt_inc > CntW'(free_fall_win_q)) begin
          ff_d     = 1'b0;
          ff_cnt_d = '0;
        end else begin
          ff_cnt_d = ff_cnt_inc;
          // Impact counts only on the check tick of the free-fall window
          if (ff_cnt_inc == CntW'(impact_tick_q) && acc_sq_q >= impact_limit_q) begin
            imp_d = 1'b1;
          end
        end
      end

      if (imp_d) begin
        if (imp_cnt_inc > CntW'(impact_win_q)) begin
          imp_d     = 1'b0;
          imp_cnt_d = '0;
        end else begin
          imp_cnt_d = imp_cnt_inc;
          // Rotation band uses the value saved in this same sample if any
          if (imp_cnt_inc < CntW'(impact_win_q) &&
              saved_rot_d >= rot_low_q && saved_rot_d <= rot_high_q) begin
            rot_d = 1'b1;
          end
        end
      end

      if (rot_d) latch_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_q        <= 1'b0;
      imp_q       <= 1'b0;
      rot_q       <= 1'b0;
      latch_q     <= 1'b0;
      ff_cnt_q    <= '0;
      imp_cnt_q   <= '0;
      saved_rot_q <= '0;
    end else if (out_load) begin
      ff_q        <= ff_d;
      imp_q       <= imp_d;
      rot_q       <= rot_d;
      latch_q     <= latch_d;
      ff_cnt_q    <= ff_cnt_d;
      imp_cnt_q   <= imp_cnt_d;
      saved_rot_q <= saved_rot_d;
    end
  end

  assign fall_detected_o   = latch_q;
  assign free_fall_armed_o = ff_q;
  assign impact_armed_o    = imp_q;
  assign rotation_armed_o  = rot_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Stage three arms in the same sample that latches, and both clear together
  a_latch_tracks_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q == rot_q)
    else $error("fall latch and stage three flag disagree");

  // An idle stage always has its count parked at zero
  a_ff_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ff_q |-> ff_cnt_q == '0)
    else $error("stage one count nonzero while idle");

  a_imp_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !imp_q |-> imp_cnt_q == '0)
    else $error("stage two count nonzero while idle");

  // A latched fall without the button leaves the state untouched
  a_latch_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q && out_load && !s2_rst_q |=>
      latch_q && $stable(ff_q) && $stable(imp_q) && $stable(saved_rot_q))
    else $error("latched state changed without reset button");

endmodule
